// File: hdl/bfs_pkg.sv
`timescale 1ns / 1ps
// Shared constants for the bit field store: field widths, request codes
// and store limits. No dependencies.
package bfs_pkg;

    localparam int WORD_W    = 64;
    localparam int INDEX_W   = 10;
    localparam int LEN_W     = 7;
    localparam int OFF_W     = 6;
    // words a field can reach (the last one only by straddling past the
    // highest bit index), and the store size by default
    localparam int MAX_WORDS = (1 << (INDEX_W - OFF_W)) + 1;
    localparam int WORDS_DEF = 16;

    localparam logic ACT_GET = 1'b0;
    localparam logic ACT_SET = 1'b1;

endpackage

// File: hdl/bfs_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// Self-contained; width and depth come from parameters.
module bfs_ram #(
    parameter int WIDTH  = 64,
    parameter int DEPTH  = 8,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port, then read port (read returns the old word on a collision)
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hdl/bit_field_store.sv
`timescale 1ns / 1ps
// Top level of the bit field store: request register, two word banks,
// field extract/insert logic and result register. Uses bfs_pkg and bfs_ram.
//
// Usage:
//   The s_ channel carries one request: get (s_action = ACT_GET) or set
//   (ACT_SET) of a field of s_field_length bits (0..64, larger values act
//   as 64) whose lowest bit sits at absolute bit s_bit_index. The m_
//   channel returns exactly one result per request: the right-aligned
//   field on a get, zero on a set, and m_out_of_range when the field runs
//   past the last bit of the store. Bits past the end read as zero and
//   are never written.
//   After acceptance a request first reads both touched words from the
//   even and odd word banks into the request stage, then merges/extracts
//   and loads the result register, which raises m_valid. Throughput is
//   one request per cycle while m_ready stays high; a set feeds the next
//   request through a bypass of the last word written to each bank.
//   Reset clears the stored words at once through per-word valid bits and
//   empties the pipeline; no sweep is needed.
//   When m_ready is low the result register holds, the request stage
//   fills, and s_ready then drops until the result is taken.
module bit_field_store #(
    parameter int WORDS = bfs_pkg::WORDS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_action,
    input  logic [bfs_pkg::INDEX_W-1:0] s_bit_index,
    input  logic [bfs_pkg::LEN_W-1:0]   s_field_length,
    input  logic [bfs_pkg::WORD_W-1:0]  s_write_value,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [bfs_pkg::WORD_W-1:0]  m_read_value,
    output logic                        m_out_of_range
);

    import bfs_pkg::*;

    localparam int STORE_DEPTH = (WORDS < MAX_WORDS) ? WORDS : MAX_WORDS;
    localparam int WNUM_W      = INDEX_W - OFF_W + 1;
    localparam int TOTAL_BITS  = WORDS * WORD_W;
    localparam int SUM_W       = INDEX_W + 1;

    // handshake
    logic s_fire, st_valid_reg, st_valid_next, advance;
    logic m_valid_reg, m_valid_next;

    // request stage
    logic                st_action_reg;
    logic [INDEX_W-1:0]  st_index_reg;
    logic [LEN_W-1:0]    st_len_reg;
    logic [WORD_W-1:0]   st_value_reg;
    logic [LEN_W-1:0]    len_sat;

    // per-bank traffic (bank 0 holds even words, bank 1 odd words)
    logic [WORD_W-1:0]   bank_cur   [2];
    logic [WORD_W-1:0]   bank_wdata [2];
    logic                bank_wen   [2];
    logic                bank_inr   [2];

    // extract / insert datapath
    logic                lo_bank;
    logic [OFF_W-1:0]    off;
    logic [LEN_W-1:0]    back_shift;
    logic [WORD_W-1:0]   mask, lo_word, hi_word, field_get, v_masked;
    logic [WORD_W-1:0]   lo_mask, hi_mask, new_lo, new_hi;
    logic [SUM_W-1:0]    end_bit;
    logic                oor;

    logic [WORD_W-1:0]   m_data_reg, m_data_next;
    logic                m_oor_reg, m_oor_next;

    assign advance = !m_valid_reg || m_ready;
    assign s_ready = !st_valid_reg || advance;
    assign s_fire  = s_valid && s_ready;
    assign len_sat = (s_field_length > LEN_W'(WORD_W)) ? LEN_W'(WORD_W) : s_field_length;

    // hold the request while its words are read
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            st_action_reg <= s_action;
            st_index_reg  <= s_bit_index;
            st_len_reg    <= len_sat;
            st_value_reg  <= s_write_value;
        end
    end

    // word banks with valid bits and last-write bypass
    for (genvar b = 0; b < 2; b++) begin : g_bank
        localparam int BANK_DEPTH = (STORE_DEPTH + 1 - b) / 2;
        localparam int BANK_AW    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

        logic [WNUM_W-1:0]     rd_word;
        logic                  rd_inr;
        logic [BANK_AW-1:0]    rd_addr;
        logic [WORD_W-1:0]     ram_q;
        logic [BANK_AW-1:0]    addr_reg;
        logic                  inr_reg;
        logic                  vld_reg;
        logic [BANK_DEPTH-1:0] valid_reg;
        logic                  last_wen_reg;
        logic [BANK_AW-1:0]    last_addr_reg;
        logic [WORD_W-1:0]     last_data_reg;

        // pick the word of this bank among the field's two words
        always_comb begin
            if (s_bit_index[OFF_W] == 1'(b)) begin
                rd_word = {1'b0, s_bit_index[INDEX_W-1:OFF_W]};
            end else begin
                rd_word = {1'b0, s_bit_index[INDEX_W-1:OFF_W]} + WNUM_W'(1);
            end
        end
        assign rd_inr  = rd_word < WNUM_W'(STORE_DEPTH);
        assign rd_addr = rd_word[BANK_AW:1];

        bfs_ram #(
            .WIDTH (WORD_W),
            .DEPTH (BANK_DEPTH)
        ) u_ram (
            .aclk  (aclk),
            .we    (bank_wen[b]),
            .waddr (addr_reg),
            .wdata (bank_wdata[b]),
            .re    (s_fire),
            .raddr (rd_addr),
            .rdata (ram_q)
        );

        // capture address and valid bit alongside the read
        always_ff @(posedge aclk) begin
            if (s_fire) begin
                addr_reg <= rd_addr;
                inr_reg  <= rd_inr;
                vld_reg  <= rd_inr && valid_reg[rd_addr];
            end
        end

        // mark written words, remember the latest write
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg    <= '0;
                last_wen_reg <= 1'b0;
            end else if (bank_wen[b]) begin
                valid_reg[addr_reg] <= 1'b1;
                last_wen_reg        <= 1'b1;
            end
        end

        always_ff @(posedge aclk) begin
            if (bank_wen[b]) begin
                last_addr_reg <= addr_reg;
                last_data_reg <= bank_wdata[b];
            end
        end

        // current word: bypass, stored, cleared or beyond the end
        always_comb begin
            if (!inr_reg) begin
                bank_cur[b] = '0;
            end else if (last_wen_reg && (last_addr_reg == addr_reg)) begin
                bank_cur[b] = last_data_reg;
            end else if (vld_reg) begin
                bank_cur[b] = ram_q;
            end else begin
                bank_cur[b] = '0;
            end
        end
        assign bank_inr[b] = inr_reg;
    end

    // extract or insert the field
    always_comb begin
        lo_bank    = st_index_reg[OFF_W];
        off        = st_index_reg[OFF_W-1:0];
        back_shift = LEN_W'(WORD_W) - {1'b0, off};
        lo_word    = bank_cur[lo_bank];
        hi_word    = bank_cur[!lo_bank];

        if (st_len_reg == LEN_W'(WORD_W)) begin
            mask = '1;
        end else begin
            mask = (WORD_W'(1) << st_len_reg) - WORD_W'(1);
        end

        field_get = lo_word >> off;
        if (off != '0) begin
            field_get = field_get | (hi_word << back_shift);
        end
        field_get = field_get & mask;

        v_masked = st_value_reg & mask;
        lo_mask  = mask << off;
        hi_mask  = (off != '0) ? (mask >> back_shift) : '0;
        new_lo   = (lo_word & ~lo_mask) | ((v_masked << off) & lo_mask);
        new_hi   = (hi_word & ~hi_mask) | ((v_masked >> back_shift) & hi_mask);

        end_bit = {1'b0, st_index_reg} + SUM_W'(st_len_reg);
        oor     = 32'(end_bit) > 32'(TOTAL_BITS);
    end

    // on a set, write back the touched words when the request moves on
    always_comb begin
        for (int b = 0; b < 2; b++) begin
            if (1'(b) == lo_bank) begin
                bank_wdata[b] = new_lo;
                bank_wen[b]   = st_valid_reg && advance && (st_action_reg == ACT_SET)
                                && bank_inr[b];
            end else begin
                bank_wdata[b] = new_hi;
                bank_wen[b]   = st_valid_reg && advance && (st_action_reg == ACT_SET)
                                && bank_inr[b] && (off != '0);
            end
        end
    end

    // advance the pipeline
    always_comb begin
        st_valid_next = st_valid_reg;
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;
        m_oor_next    = m_oor_reg;
        if (advance) begin
            m_valid_next  = st_valid_reg;
            st_valid_next = 1'b0;
            if (st_valid_reg) begin
                m_data_next = (st_action_reg == ACT_GET) ? field_get : '0;
                m_oor_next  = oor;
            end
        end
        if (s_fire) begin
            st_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            st_valid_reg <= st_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
        m_oor_reg  <= m_oor_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_read_value   = m_data_reg;
    assign m_out_of_range = m_oor_reg;

endmodule
